// ===== rtl/core/trc_pkg.sv =====
// Package for the text readability counter: character codes, reset values
// and the per-byte class record shared by the classifier and the counters.
// No dependencies.
package trc_pkg;

  localparam int unsigned COUNT_BITS_DEF = 24;
  localparam int unsigned NUM_FIELDS     = 5;
  localparam int unsigned CHAR_BITS      = 8;
  localparam int unsigned RUN_BITS       = 6;

  localparam logic [CHAR_BITS-1:0] CHAR_TERM  = 8'h00;
  localparam logic [CHAR_BITS-1:0] CHAR_DOT   = 8'h2E;  // '.'
  localparam logic [CHAR_BITS-1:0] CHAR_BANG  = 8'h21;  // '!'
  localparam logic [CHAR_BITS-1:0] CHAR_QUEST = 8'h3F;  // '?'
  localparam logic [CHAR_BITS-1:0] CHAR_LO_A  = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_LO_E  = 8'h65;
  localparam logic [CHAR_BITS-1:0] CHAR_LO_I  = 8'h69;
  localparam logic [CHAR_BITS-1:0] CHAR_LO_O  = 8'h6F;
  localparam logic [CHAR_BITS-1:0] CHAR_LO_U  = 8'h75;
  localparam logic [CHAR_BITS-1:0] CHAR_LO_Y  = 8'h79;
  localparam logic [CHAR_BITS-1:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [CHAR_BITS-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CASE_BIT   = 8'h20;

  localparam logic [RUN_BITS-1:0] RUN_MAX        = '1;
  localparam logic [RUN_BITS-1:0] LONG_MIN_RESET = 6'd6;

  typedef struct packed {
    logic is_term;
    logic is_letter;
    logic is_vowel;
    logic is_mark;
  } char_class_t;

endpackage

// ===== rtl/core/trc_classify.sv =====
// Byte classifier: letter, vowel, sentence mark and terminator flags.
// Depends on trc_pkg.
module trc_classify (
  input  logic [trc_pkg::CHAR_BITS-1:0] char_i,
  output trc_pkg::char_class_t          class_o
);
  import trc_pkg::*;

  logic                 upper;
  logic                 lower;
  logic [CHAR_BITS-1:0] folded;

  always_comb begin
    upper  = (char_i >= CHAR_UP_A) && (char_i <= CHAR_UP_Z);
    lower  = (char_i >= CHAR_LO_A) && (char_i <= CHAR_LO_Z);
    folded = upper ? (char_i | CASE_BIT) : char_i;

    class_o.is_term   = (char_i == CHAR_TERM);
    class_o.is_letter = upper || lower;
    class_o.is_vowel  = folded inside {CHAR_LO_A, CHAR_LO_E, CHAR_LO_I,
                                       CHAR_LO_O, CHAR_LO_U, CHAR_LO_Y};
    class_o.is_mark   = char_i inside {CHAR_DOT, CHAR_BANG, CHAR_QUEST};
  end

endmodule

// ===== rtl/core/trc_count.sv =====
// Running text statistics: open word length, vowel run flag and the five
// saturating counters, with the closed-out totals for the terminator.
// Depends on trc_pkg.
module trc_count #(
  parameter int unsigned COUNT_BITS = trc_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  trc_pkg::char_class_t         class_i,
  input  logic [trc_pkg::RUN_BITS-1:0] long_min_i,
  output logic [COUNT_BITS-1:0]        words_o,
  output logic [COUNT_BITS-1:0]        letters_o,
  output logic [COUNT_BITS-1:0]        marks_o,
  output logic [COUNT_BITS-1:0]        groups_o,
  output logic [COUNT_BITS-1:0]        long_o
);
  import trc_pkg::*;

  localparam logic [COUNT_BITS-1:0] CntMax = '1;
  localparam logic [COUNT_BITS-1:0] CntOne = COUNT_BITS'(1);

  logic [RUN_BITS-1:0]   run_q, run_d;
  logic                  prev_vowel_q, prev_vowel_d;
  logic [COUNT_BITS-1:0] words_q, words_d;
  logic [COUNT_BITS-1:0] letters_q, letters_d;
  logic [COUNT_BITS-1:0] marks_q, marks_d;
  logic [COUNT_BITS-1:0] groups_q, groups_d;
  logic [COUNT_BITS-1:0] long_q, long_d;
  logic                  close_word;

  always_comb begin
    close_word = !class_i.is_letter && (run_q != '0);

    words_d   = words_q;
    long_d    = long_q;
    letters_d = letters_q;
    marks_d   = marks_q;
    groups_d  = groups_q;
    run_d     = run_q;

    if (class_i.is_letter) begin
      if (letters_q != CntMax) letters_d = letters_q + CntOne;
      if (run_q != RUN_MAX) run_d = run_q + RUN_BITS'(1);
    end else begin
      run_d = '0;
    end

    if (close_word) begin
      if (words_q != CntMax) words_d = words_q + CntOne;
      if ((run_q >= long_min_i) && (long_q != CntMax)) long_d = long_q + CntOne;
    end

    if (class_i.is_mark && (marks_q != CntMax)) marks_d = marks_q + CntOne;

    if (class_i.is_vowel && !prev_vowel_q && (groups_q != CntMax)) begin
      groups_d = groups_q + CntOne;
    end
    prev_vowel_d = class_i.is_vowel;

    // Totals as reported at the terminator, with the open word closed.
    words_o   = words_d;
    letters_o = letters_d;
    marks_o   = (marks_d == '0) ? CntOne : marks_d;
    groups_o  = (groups_d == '0) ? CntOne : groups_d;
    long_o    = long_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q        <= '0;
      prev_vowel_q <= 1'b0;
      words_q      <= '0;
      letters_q    <= '0;
      marks_q      <= '0;
      groups_q     <= '0;
      long_q       <= '0;
    end else if (step_i) begin
      if (class_i.is_term) begin
        // drop all running state once the totals are out
        run_q        <= '0;
        prev_vowel_q <= 1'b0;
        words_q      <= '0;
        letters_q    <= '0;
        marks_q      <= '0;
        groups_q     <= '0;
        long_q       <= '0;
      end else begin
        run_q        <= run_d;
        prev_vowel_q <= prev_vowel_d;
        words_q      <= words_d;
        letters_q    <= letters_d;
        marks_q      <= marks_d;
        groups_q     <= groups_d;
        long_q       <= long_d;
      end
    end
  end

endmodule

// ===== rtl/core/text_readability_counter_top.sv =====
// Text readability counter, top level. One byte per cycle sustained while no
// terminator waits for the result register; the counter update for a byte is
// combinational logic between the input register and the counter registers.
// A terminator passes the input register, then the result register. A full
// result register with tready low holds a terminator in the input register
// and stalls the input behind it; other bytes alone never stall.
// Reset clears all counters and flags and sets long_word_min to 6.
module text_readability_counter_top #(
  parameter int unsigned COUNT_BITS = trc_pkg::COUNT_BITS_DEF,
  localparam int unsigned FieldW = trc_pkg::NUM_FIELDS * COUNT_BITS,
  localparam int unsigned OutW   = ((FieldW + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [trc_pkg::RUN_BITS-1:0]  cfg_data_i,     // long_word_min
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [trc_pkg::CHAR_BITS-1:0] s_axis_tdata,   // char_code
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // word_count, letter_count, sentence_count, syllable_count, long_word_count
  output logic [OutW-1:0]               m_axis_tdata
);
  import trc_pkg::*;

  logic                 in_valid_q;
  logic [CHAR_BITS-1:0] in_char_q;
  logic [RUN_BITS-1:0]  long_min_q;
  logic                 out_valid_q;
  logic [FieldW-1:0]    out_data_q;
  logic                 step;
  char_class_t          char_class;
  logic [COUNT_BITS-1:0] words, letters, marks, groups, longs;

  trc_classify u_classify (
    .char_i  (in_char_q),
    .class_o (char_class)
  );

  trc_count #(
    .COUNT_BITS (COUNT_BITS)
  ) u_count (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .class_i    (char_class),
    .long_min_i (long_min_q),
    .words_o    (words),
    .letters_o  (letters),
    .marks_o    (marks),
    .groups_o   (groups),
    .long_o     (longs)
  );

  // Only a terminator needs room in the result register.
  assign step          = in_valid_q && (!char_class.is_term || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'(out_data_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      long_min_q  <= LONG_MIN_RESET;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (cfg_valid_i) long_min_q <= cfg_data_i;
      if (step && char_class.is_term) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_char_q <= s_axis_tdata;
    if (step && char_class.is_term) begin
      out_data_q <= {longs, groups, marks, letters, words};
    end
  end

endmodule

// ===== rtl/core/trc_checker.sv =====
// Port-level checks for the text readability counter, bound to the top.
// Depends on text_readability_counter_top ports only.
module trc_checker #(
  parameter int unsigned COUNT_BITS = 24,
  localparam int unsigned OutW = ((5 * COUNT_BITS + 7) / 8) * 8
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic [7:0]      s_axis_tdata,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);

  logic [COUNT_BITS-1:0] words, letters, marks, groups, longs;
  logic                  term_in;

  assign words   = m_axis_tdata[COUNT_BITS-1:0];
  assign letters = m_axis_tdata[2*COUNT_BITS-1:COUNT_BITS];
  assign marks   = m_axis_tdata[3*COUNT_BITS-1:2*COUNT_BITS];
  assign groups  = m_axis_tdata[4*COUNT_BITS-1:3*COUNT_BITS];
  assign longs   = m_axis_tdata[5*COUNT_BITS-1:4*COUNT_BITS];
  assign term_in = s_axis_tvalid && s_axis_tready && (s_axis_tdata == 8'h00);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (marks != '0) && (groups != '0))
    else $error("sentence or syllable count below one");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (longs <= words) && (words <= letters))
    else $error("long words exceed words, or words exceed letters");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_in |=> ##1 m_axis_tvalid)
    else $error("terminator produced no result");

endmodule

bind text_readability_counter_top trc_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_trc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
